/* hw/rtl/tgs_pkg.sv */
// ----------------------------------------------------------------------------
// Turmite grid stepper package
// Shared types and constants: rule word layout, turn and heading codes, and
// the result record that travels from the step logic to the output queue.
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int NUM_RULE_REGS = 8;
    localparam int RULE_W        = 13;
    localparam int CFG_IDX_W     = 3;
    localparam int COLOR_W       = 3;
    localparam int STATE_W       = 2;
    localparam int X_W           = 10;
    localparam int Y_W           = 9;

    typedef enum logic [1:0] {
        HEAD_UP    = 2'd0,
        HEAD_RIGHT = 2'd1,
        HEAD_DOWN  = 2'd2,
        HEAD_LEFT  = 2'd3
    } heading_t;

    // Codes 0 and 3 both leave the heading alone.
    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_RIGHT = 2'd1,
        TURN_LEFT  = 2'd2,
        TURN_KEEP  = 2'd3
    } turn_t;

    typedef struct packed {
        logic [STATE_W-1:0] goto_state;
        turn_t              turn;
        logic [COLOR_W-1:0] wr_color;
        logic [COLOR_W-1:0] color;
        logic [STATE_W-1:0] state;
        logic               valid;
    } rule_t;

    typedef struct packed {
        logic               hit;
        logic [COLOR_W-1:0] wr_color;
        turn_t              turn;
        logic [STATE_W-1:0] goto_state;
    } match_t;

    typedef struct packed {
        logic               halted;
        logic               wrote;
        logic [X_W-1:0]     cell_x;
        logic [Y_W-1:0]     cell_y;
        logic [COLOR_W-1:0] cell_color;
    } result_t;

    localparam logic [RULE_W-1:0] RULE_RESET [NUM_RULE_REGS] = '{
        13'd577, 13'd649, 13'd1233, 13'd1305,
        13'd1377, 13'd1449, 13'd1009, 13'd569
    };

endpackage

/* hw/rtl/tgs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tgs_ram #(
    parameter int WIDTH  = 3,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tgs_rule_match.sv */
// ----------------------------------------------------------------------------
// Turmite rule matcher
// Finds the lowest-numbered valid rule whose state and color match.
// ----------------------------------------------------------------------------
module tgs_rule_match #(
    parameter int RULE_COUNT = 8
) (
    input  tgs_pkg::rule_t                   rules [RULE_COUNT],
    input  logic [tgs_pkg::STATE_W-1:0]      mstate,
    input  logic [tgs_pkg::COLOR_W-1:0]      color,
    output tgs_pkg::match_t                  match
);

    import tgs_pkg::*;

    always_comb begin
        match = '0;
        // Walk from the top so that the lowest matching index wins.
        for (int i = RULE_COUNT - 1; i >= 0; i--) begin
            if (rules[i].valid && rules[i].state == mstate && rules[i].color == color) begin
                match.hit        = 1'b1;
                match.wr_color   = rules[i].wr_color;
                match.turn       = rules[i].turn;
                match.goto_state = rules[i].goto_state;
            end
        end
    end

endmodule

/* hw/rtl/tgs_out_fifo.sv */
// ----------------------------------------------------------------------------
// Two-entry result queue
// Decouples the step logic from a stalling receiver.
// ----------------------------------------------------------------------------
module tgs_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tgs_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output tgs_pkg::result_t out_data
);

    import tgs_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/turmite_grid_stepper_top.sv */
// ----------------------------------------------------------------------------
// Turmite grid stepper
// A multi-color turmite walking a toroidal grid held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries one bit, advance. With advance set the ant reads
// the color under it, applies the first matching rule (writes a new color,
// turns, changes state, moves one cell with wrap-around) and reports the
// written cell. With advance clear, or once halted, the word only reports
// the ant's cell and its present color. No matching rule halts the ant.
// Rules are written through cfg_wr_en/cfg_index/cfg_data while idle.
// After reset the grid RAM is cleared one cell per cycle; s_tready stays
// low meanwhile and while the first cell is read afterwards.
// The result word is pushed into the result queue when its word is
// accepted and is presented on m_tvalid and m_tdata from there.
// After a word that writes a cell, s_tready stays low until the registered
// read of the grid RAM has returned the cell under the new position; other
// words do not hold it low. A two-entry result queue lets the block go on
// while the receiver stalls; when it fills, s_tready drops.
// ----------------------------------------------------------------------------
module turmite_grid_stepper_top #(
    parameter int GRID_WIDTH  = 640,
    parameter int GRID_HEIGHT = 264,
    parameter int RULE_COUNT  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] advance
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [9:0] cell_x, [18:10] cell_y,
                                                      // [21:19] cell_color
    output logic [1:0]                     m_tuser,   // [0] halted, [1] wrote
    input  logic                           cfg_wr_en,
    input  logic [tgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgs_pkg::RULE_W-1:0]     cfg_data
);

    import tgs_pkg::*;

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam logic [X_W-1:0] X_MAX    = X_W'(GRID_WIDTH - 1);
    localparam logic [Y_W-1:0] Y_MAX    = Y_W'(GRID_HEIGHT - 1);
    localparam logic [X_W-1:0] X_CENTER = X_W'(GRID_WIDTH / 2);
    localparam logic [Y_W-1:0] Y_CENTER = Y_W'(GRID_HEIGHT / 2);
    localparam logic [AW-1:0]  ADDR_CENTER =
        AW'((GRID_HEIGHT / 2) * GRID_WIDTH + GRID_WIDTH / 2);
    localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0]  ROW_STEP  = AW'(GRID_WIDTH);
    localparam logic [AW-1:0]  WRAP_X    = AW'(GRID_WIDTH - 1);
    localparam logic [AW-1:0]  WRAP_Y    = AW'((GRID_HEIGHT - 1) * GRID_WIDTH);

    rule_t              rules_reg [RULE_COUNT];
    logic [X_W-1:0]     pos_x_reg, pos_x_next;
    logic [Y_W-1:0]     pos_y_reg, pos_y_next;
    logic [AW-1:0]      addr_reg, addr_next;
    heading_t           heading_reg, heading_next;
    logic [STATE_W-1:0] mstate_reg, mstate_next;
    logic               dead_reg, dead_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               clearing_reg, clearing_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;

    logic               s_fire;
    logic               do_step;
    logic               step_we;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;
    match_t             match;
    result_t            result;
    result_t            out_data;
    logic               fifo_full;

    tgs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_grid_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    tgs_rule_match #(
        .RULE_COUNT(RULE_COUNT)
    ) u_rule_match (
        .rules (rules_reg),
        .mstate(mstate_reg),
        .color (ram_rdata),
        .match (match)
    );

    tgs_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_fire),
        .push_data(result),
        .full     (fifo_full),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_data)
    );

    // The RAM output is trusted only while rd_valid_reg, the registered inverse of the write enable, is set,
    // since the read address follows the ant and only moves together with a write.
    assign s_tready = rd_valid_reg && !clearing_reg && !fifo_full;
    assign s_fire   = s_tvalid && s_tready;
    assign do_step  = s_fire && s_tdata[0] && !dead_reg;
    assign step_we  = do_step && match.hit;

    assign ram_we    = clearing_reg || step_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : addr_reg;
    assign ram_wdata = clearing_reg ? '0 : match.wr_color;

    always_comb begin
        heading_next  = heading_reg;
        mstate_next   = mstate_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        addr_next     = addr_reg;
        dead_next     = dead_reg || (do_step && !match.hit);
        rd_valid_next = !ram_we;
        clearing_next = clearing_reg && (clr_addr_reg != ADDR_LAST);
        clr_addr_next = clearing_reg ? clr_addr_reg + AW'(1) : clr_addr_reg;

        if (step_we) begin
            unique case (match.turn)
                TURN_RIGHT: heading_next = heading_t'(heading_reg + 2'd1);
                TURN_LEFT:  heading_next = heading_t'(heading_reg + 2'd3);
                TURN_NONE,
                TURN_KEEP:  heading_next = heading_reg;
                default:    heading_next = heading_reg;
            endcase
            mstate_next = match.goto_state;

            unique case (heading_next)
                HEAD_UP: begin
                    if (pos_y_reg == '0) begin
                        pos_y_next = Y_MAX;
                        addr_next  = addr_reg + WRAP_Y;
                    end else begin
                        pos_y_next = pos_y_reg - Y_W'(1);
                        addr_next  = addr_reg - ROW_STEP;
                    end
                end
                HEAD_DOWN: begin
                    if (pos_y_reg == Y_MAX) begin
                        pos_y_next = '0;
                        addr_next  = addr_reg - WRAP_Y;
                    end else begin
                        pos_y_next = pos_y_reg + Y_W'(1);
                        addr_next  = addr_reg + ROW_STEP;
                    end
                end
                HEAD_LEFT: begin
                    if (pos_x_reg == '0) begin
                        pos_x_next = X_MAX;
                        addr_next  = addr_reg + WRAP_X;
                    end else begin
                        pos_x_next = pos_x_reg - X_W'(1);
                        addr_next  = addr_reg - AW'(1);
                    end
                end
                HEAD_RIGHT: begin
                    if (pos_x_reg == X_MAX) begin
                        pos_x_next = '0;
                        addr_next  = addr_reg - WRAP_X;
                    end else begin
                        pos_x_next = pos_x_reg + X_W'(1);
                        addr_next  = addr_reg + AW'(1);
                    end
                end
                default: begin
                    pos_x_next = pos_x_reg;
                end
            endcase
        end
    end

    always_comb begin
        result.halted     = dead_next;
        result.wrote      = step_we;
        result.cell_x     = pos_x_reg;
        result.cell_y     = pos_y_reg;
        result.cell_color = step_we ? match.wr_color : ram_rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RULE_COUNT; i++) begin
                rules_reg[i] <= rule_t'(RULE_RESET[i]);
            end
            pos_x_reg    <= X_CENTER;
            pos_y_reg    <= Y_CENTER;
            addr_reg     <= ADDR_CENTER;
            heading_reg  <= HEAD_RIGHT;
            mstate_reg   <= '0;
            dead_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            for (int i = 0; i < RULE_COUNT; i++) begin
                if (cfg_wr_en && cfg_index == CFG_IDX_W'(i)) begin
                    rules_reg[i] <= rule_t'(cfg_data);
                end
            end
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            addr_reg     <= addr_next;
            heading_reg  <= heading_next;
            mstate_reg   <= mstate_next;
            dead_reg     <= dead_next;
            rd_valid_reg <= rd_valid_next;
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign m_tdata = {2'b00, out_data.cell_color, out_data.cell_y, out_data.cell_x};
    assign m_tuser = {out_data.wrote, out_data.halted};

    // Once halted, the ant stays halted until reset.
    assert property (@(posedge aclk) disable iff (!aresetn) dead_reg |=> dead_reg)
        else $error("halt flag cleared without reset");

    // A step write only happens on valid read data and never during clearing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_we |-> (rd_valid_reg && !clearing_reg))
        else $error("step write on stale read data");

    // After a step write the next word must wait for the new cell's read.
    assert property (@(posedge aclk) disable iff (!aresetn) step_we |=> !s_tready)
        else $error("word accepted before the new cell was read");

    // Nothing is accepted while the grid is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn) clearing_reg |-> !s_tready)
        else $error("word accepted during grid clearing");

endmodule
